// File: src/prr_pkg.sv
// Shared types, constants and helper functions for the permutation rank/unrank block.
// No dependencies; every other file in src imports this package.

package prr_pkg;

    localparam int MAX_PIECES = 7;
    localparam int PIECE_BITS = 3;
    localparam int VALUE_BITS = 3;
    localparam int COUNT_W    = 3;
    localparam int RANK_W     = 13;
    localparam int PERM_W     = MAX_PIECES * PIECE_BITS;
    localparam int SEEN_W     = 1 << VALUE_BITS;

    typedef enum logic
    {
        OP_RANK   = 1'b0,
        OP_UNRANK = 1'b1
    } op_t;

    typedef logic [VALUE_BITS-1:0] piece_t;

    // piece[k] is the digit of weight k!, i.e. the piece at position count-1-k
    typedef struct packed
    {
        logic [COUNT_W-1:0]          count;
        piece_t [MAX_PIECES-1:0]     piece;
        logic [RANK_W-1:0]           rank;
    } req_t;

    typedef struct packed
    {
        piece_t            digit;
        logic [RANK_W-1:0] rem;
    } fdig_t;

    function automatic logic [RANK_W-1:0] fact(input int k);
        logic [RANK_W-1:0] f;
        unique case (k)
            0:       f = RANK_W'(1);
            1:       f = RANK_W'(1);
            2:       f = RANK_W'(2);
            3:       f = RANK_W'(6);
            4:       f = RANK_W'(24);
            5:       f = RANK_W'(120);
            6:       f = RANK_W'(720);
            7:       f = RANK_W'(5040);
            default: f = '0;
        endcase
        return f;
    endfunction

    // One factorial digit by parallel compares against the multiples of k!
    function automatic fdig_t split_digit(input logic [RANK_W-1:0] r, input int k);
        fdig_t             res;
        logic [RANK_W-1:0] sub;
        res.digit = '0;
        sub       = '0;
        for (int m = 1; m <= k; m++)
        begin
            if (r >= RANK_W'(m * int'(fact(k))))
            begin
                res.digit = VALUE_BITS'(m);
                sub       = RANK_W'(m * int'(fact(k)));
            end
        end
        res.rem = r - sub;
        return res;
    endfunction

endpackage

// File: src/permutation_rank_unrank.sv
// Top level of the permutation rank/unrank converter.
// Depends on prr_pkg, prr_rank_path and prr_unrank_path.
//
// Usage:
//   A command is transferred at a rising edge with start high and busy low.
//   busy is never raised: a new command may be given in every cycle.
//   operation selects ranking (perm_in -> rank_out) or unranking
//   (rank_in -> perm_out); piece_count gives the number of 3-bit pieces,
//   piece 0 in the most significant used digit of perm_in / perm_out.
//   Each result shows for one cycle with done high and is transferred
//   while done is high; the command on its way passes through one input
//   register, four pipeline stages, one output register. Throughput is one
//   conversion per cycle; the depth is set by the unrank path (range check
//   with the top digit, two more digit-split stages, fix-up and packing).
//   Fields not produced by the chosen operation read zero. A rank not below
//   piece_count! sets rank_invalid with perm_out and rank_out zero.
//   The receiver cannot stall: every result is transferred in its cycle.
//   Reset clears all valid bits and done; results in flight are dropped.

module permutation_rank_unrank
    import prr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              operation,
    input  logic [COUNT_W-1:0] piece_count,
    input  logic [PERM_W-1:0] perm_in,
    input  logic [RANK_W-1:0] rank_in,
    output logic              done,
    output logic [PERM_W-1:0] perm_out,
    output logic [RANK_W-1:0] rank_out,
    output logic              rank_invalid
);

    logic               s0_valid_reg;
    logic               s0_valid_next;
    op_t                s0_op_reg;
    req_t               s0_req_reg;
    req_t               s0_req_next;
    logic [COUNT_W-1:0] count_sat;

    logic               rank_valid;
    logic [RANK_W-1:0]  rank_res;
    logic               unrank_valid;
    logic               unrank_inv;
    logic [PERM_W-1:0]  perm_res;

    logic               done_reg;
    logic               done_next;
    logic [PERM_W-1:0]  perm_out_reg;
    logic [PERM_W-1:0]  perm_out_next;
    logic [RANK_W-1:0]  rank_out_reg;
    logic [RANK_W-1:0]  rank_out_next;
    logic               inv_reg;
    logic               inv_next;

    assign busy          = 1'b0;
    assign s0_valid_next = start && !busy;

    always_comb
    begin
        if (piece_count > COUNT_W'(MAX_PIECES))
            count_sat = COUNT_W'(MAX_PIECES);
        else
            count_sat = piece_count;
        s0_req_next.count = count_sat;
        s0_req_next.rank  = rank_in;
        for (int k = 0; k < MAX_PIECES; k++)
        begin
            if (k < int'(count_sat))
                s0_req_next.piece[k] = perm_in[k*PIECE_BITS +: VALUE_BITS];
            else
                s0_req_next.piece[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_op_reg    <= op_t'(operation);
        s0_req_reg   <= s0_req_next;
        perm_out_reg <= perm_out_next;
        rank_out_reg <= rank_out_next;
        inv_reg      <= inv_next;
    end

    prr_rank_path u_rank
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s0_valid_reg && s0_op_reg == OP_RANK),
        .req       (s0_req_reg),
        .valid_out (rank_valid),
        .rank      (rank_res)
    );

    prr_unrank_path u_unrank
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s0_valid_reg && s0_op_reg == OP_UNRANK),
        .req       (s0_req_reg),
        .valid_out (unrank_valid),
        .invalid   (unrank_inv),
        .perm      (perm_res)
    );

    // unused fields and idle cycles read zero
    assign done_next     = rank_valid || unrank_valid;
    assign rank_out_next = rank_valid ? rank_res : '0;
    assign perm_out_next = unrank_valid ? perm_res : '0;
    assign inv_next      = unrank_valid && unrank_inv;

    assign done         = done_reg;
    assign perm_out     = perm_out_reg;
    assign rank_out     = rank_out_reg;
    assign rank_invalid = inv_reg;

endmodule

// File: src/prr_rank_path.sv
// Ranking pipeline: Lehmer digits, factorial-weighted sum, two delay stages.
// Depends on prr_pkg.

module prr_rank_path
    import prr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  req_t              req,
    output logic              valid_out,
    output logic [RANK_W-1:0] rank
);

    logic [3:0]              valid_reg;
    logic [3:0]              valid_next;
    piece_t [MAX_PIECES-1:0] a_digit_reg;
    piece_t [MAX_PIECES-1:0] a_digit_next;
    logic [RANK_W-1:0]       b_sum_reg;
    logic [RANK_W-1:0]       b_sum_next;
    logic [RANK_W-1:0]       c_sum_reg;
    logic [RANK_W-1:0]       d_sum_reg;

    assign valid_next = {valid_reg[2:0], valid_in};

    // digit = value minus number of distinct smaller values at earlier positions
    always_comb
    begin
        logic [SEEN_W-1:0]  seen;
        logic [VALUE_BITS:0] cnt;
        for (int k = 0; k < MAX_PIECES; k++)
        begin
            seen = '0;
            for (int m = k + 1; m < MAX_PIECES; m++)
            begin
                if (m < int'(req.count))
                    seen[req.piece[m]] = 1'b1;
            end
            cnt = '0;
            for (int b = 0; b < SEEN_W; b++)
            begin
                if (b < int'(req.piece[k]) && seen[b])
                    cnt = cnt + 1'b1;
            end
            a_digit_next[k] = req.piece[k] - VALUE_BITS'(cnt);
        end
    end

    always_comb
    begin
        b_sum_next = '0;
        for (int k = 0; k < MAX_PIECES; k++)
            b_sum_next = b_sum_next + RANK_W'(a_digit_reg[k] * fact(k));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        a_digit_reg <= a_digit_next;
        b_sum_reg   <= b_sum_next;
        c_sum_reg   <= b_sum_reg;
        d_sum_reg   <= c_sum_reg;
    end

    assign valid_out = valid_reg[3];
    assign rank      = d_sum_reg;

endmodule

// File: src/prr_unrank_path.sv
// Unranking pipeline: range check, factorial digit split over three stages,
// increment fix-up and packing. Depends on prr_pkg.

module prr_unrank_path
    import prr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  req_t              req,
    output logic              valid_out,
    output logic              invalid,
    output logic [PERM_W-1:0] perm
);

    localparam int TOP_K = MAX_PIECES - 1;

    logic [3:0]              valid_reg;
    logic [3:0]              valid_next;
    logic [COUNT_W-1:0]      a_count_reg, b_count_reg, c_count_reg;
    logic                    a_inv_reg, b_inv_reg, c_inv_reg, d_inv_reg;
    logic                    a_inv_next;
    logic [RANK_W-1:0]       a_rem_reg, b_rem_reg;
    logic [RANK_W-1:0]       a_rem_next, b_rem_next;
    piece_t [MAX_PIECES-1:0] a_dig_reg, b_dig_reg, c_dig_reg;
    piece_t [MAX_PIECES-1:0] a_dig_next, b_dig_next, c_dig_next;
    logic [PERM_W-1:0]       d_perm_reg;
    logic [PERM_W-1:0]       d_perm_next;

    assign valid_next = {valid_reg[2:0], valid_in};

    // stage A: range check and top digit
    always_comb
    begin
        fdig_t fd;
        a_inv_next = req.rank >= fact(int'(req.count));
        fd         = split_digit(req.rank, TOP_K);
        a_dig_next = '0;
        a_dig_next[TOP_K] = fd.digit;
        a_rem_next = fd.rem;
    end

    // stage B: next two digits
    always_comb
    begin
        fdig_t             fd;
        logic [RANK_W-1:0] r;
        b_dig_next = a_dig_reg;
        r          = a_rem_reg;
        for (int k = TOP_K - 1; k >= TOP_K - 2 && k >= 1; k--)
        begin
            fd            = split_digit(r, k);
            b_dig_next[k] = fd.digit;
            r             = fd.rem;
        end
        b_rem_next = r;
    end

    // stage C: remaining digits, weight 0! digit is always zero
    always_comb
    begin
        fdig_t             fd;
        logic [RANK_W-1:0] r;
        c_dig_next = b_dig_reg;
        r          = b_rem_reg;
        for (int k = TOP_K - 3; k >= 1; k--)
        begin
            fd            = split_digit(r, k);
            c_dig_next[k] = fd.digit;
            r             = fd.rem;
        end
    end

    // stage D: raise each digit once per earlier digit not above it, then pack
    always_comb
    begin
        piece_t v;
        d_perm_next = '0;
        for (int k = 0; k < MAX_PIECES; k++)
        begin
            v = c_dig_reg[k];
            for (int m = k + 1; m < MAX_PIECES; m++)
            begin
                if (m < int'(c_count_reg) && c_dig_reg[m] <= v)
                    v = v + 1'b1;
            end
            if (k < int'(c_count_reg) && !c_inv_reg)
                d_perm_next[k*PIECE_BITS +: PIECE_BITS] = PIECE_BITS'(v);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        a_count_reg <= req.count;
        a_inv_reg   <= a_inv_next;
        a_rem_reg   <= a_rem_next;
        a_dig_reg   <= a_dig_next;
        b_count_reg <= a_count_reg;
        b_inv_reg   <= a_inv_reg;
        b_rem_reg   <= b_rem_next;
        b_dig_reg   <= b_dig_next;
        c_count_reg <= b_count_reg;
        c_inv_reg   <= b_inv_reg;
        c_dig_reg   <= c_dig_next;
        d_inv_reg   <= c_inv_reg;
        d_perm_reg  <= d_perm_next;
    end

    assign valid_out = valid_reg[3];
    assign invalid   = d_inv_reg;
    assign perm      = d_perm_reg;

endmodule

// File: src/prr_checker.sv
// Port-level checks for permutation_rank_unrank, attached by bind.
// Depends on prr_pkg.

module prr_checker
    import prr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               operation,
    input logic               done,
    input logic [PERM_W-1:0]  perm_out,
    input logic [RANK_W-1:0]  rank_out,
    input logic               rank_invalid
);

    localparam int LAT = 6;

    // every transfer gives one result at fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("result missing after command");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without command");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rank_invalid |-> perm_out == '0 && rank_out == '0)
        else $error("invalid rank with non-zero payload");

    a_rank_mode: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(operation, LAT) == OP_RANK |-> perm_out == '0 && !rank_invalid)
        else $error("rank result carries unrank fields");

endmodule

bind permutation_rank_unrank prr_checker u_prr_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the permutation rank/unrank converter.
// Depends on prr_pkg and permutation_rank_unrank; drives commands from a queue and checks
// every result against a local Lehmer-code predictor.
`timescale 1ns / 1ps

module testbench;
    import prr_pkg::*;

    typedef struct
    {
        op_t                op;
        logic [COUNT_W-1:0] count;
        logic [PERM_W-1:0]  perm;
        logic [RANK_W-1:0]  rank;
        bit                 hold;   // wait for the pipeline to empty before this one
    } conv_cmd_t;

    typedef struct
    {
        logic [PERM_W-1:0] perm;
        logic [RANK_W-1:0] rank;
        logic              invalid;
    } conv_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               operation = 1'b0;
    logic [COUNT_W-1:0] piece_count = '0;
    logic [PERM_W-1:0]  perm_in = '0;
    logic [RANK_W-1:0]  rank_in = '0;
    logic               done;
    logic [PERM_W-1:0]  perm_out;
    logic [RANK_W-1:0]  rank_out;
    logic               rank_invalid;

    conv_cmd_t    pending_cmds[$];
    conv_result_t expected_results[$];
    conv_cmd_t    cur_cmd;
    int           gap_left = 0;
    int           burst_left = 0;
    bit           burst_mode = 1'b0;
    int           fail_count = 0;

    permutation_rank_unrank u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .piece_count  (piece_count),
        .perm_in      (perm_in),
        .rank_in      (rank_in),
        .done         (done),
        .perm_out     (perm_out),
        .rank_out     (rank_out),
        .rank_invalid (rank_invalid)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int unsigned factorial(input int k);
        int unsigned f;
        f = 1;
        for (int m = 2; m <= k; m++)
        begin
            f = f * m;
        end
        return f;
    endfunction

    // Lehmer digit = value minus count of distinct smaller values already seen
    function automatic logic [RANK_W-1:0] lehmer_rank(input logic [PERM_W-1:0] perm, input int n);
        logic [7:0]  seen;
        int unsigned total;
        int unsigned val;
        int unsigned smaller;
        seen  = '0;
        total = 0;
        for (int i = 0; i < n; i++)
        begin
            val     = perm[(n - 1 - i) * PIECE_BITS +: 3];
            smaller = 0;
            for (int v = 0; v < 8; v++)
            begin
                if (v < val && seen[v])
                    smaller++;
            end
            total      = total + (val - smaller) * factorial(n - 1 - i);
            seen[val]  = 1'b1;
        end
        return total[RANK_W-1:0];
    endfunction

    function automatic logic [PERM_W-1:0] lehmer_unrank(input int unsigned r, input int n);
        int unsigned       digit[0:7];
        int unsigned       f;
        logic [PERM_W-1:0] perm_word;
        for (int i = 0; i < n; i++)
        begin
            f        = factorial(n - 1 - i);
            digit[i] = r / f;
            r        = r % f;
        end
        // increment fix-up, last position first
        for (int i = n - 1; i > 0; i--)
        begin
            for (int j = i - 1; j >= 0; j--)
            begin
                if (digit[j] <= digit[i])
                    digit[i]++;
            end
        end
        perm_word = '0;
        for (int i = 0; i < n; i++)
        begin
            perm_word = (perm_word << PIECE_BITS) | PERM_W'(digit[i] & 7);
        end
        return perm_word;
    endfunction

    function automatic conv_result_t predict_conversion(input conv_cmd_t cmd);
        conv_result_t res;
        int           n;
        n   = (cmd.count > MAX_PIECES) ? MAX_PIECES : int'(cmd.count);
        res = '{perm: '0, rank: '0, invalid: 1'b0};
        if (cmd.op == OP_RANK)
            res.rank = lehmer_rank(cmd.perm, n);
        else if (cmd.rank >= factorial(n))
            res.invalid = 1'b1;
        else
            res.perm = lehmer_unrank(cmd.rank, n);
        return res;
    endfunction

    task automatic add_cmd(input op_t op, input int n, input logic [PERM_W-1:0] perm,
                           input logic [RANK_W-1:0] rank, input bit hold = 1'b0);
        conv_cmd_t cmd;
        cmd.op    = op;
        cmd.count = COUNT_W'(n);
        cmd.perm  = perm;
        cmd.rank  = rank;
        cmd.hold  = hold;
        pending_cmds.push_back(cmd);
    endtask

    // valid permutation of 0..n-1 in the low digits, random junk above
    function automatic logic [PERM_W-1:0] random_perm(input int n);
        int                vals[0:6];
        int                k;
        int                tmp;
        logic [PERM_W-1:0] perm_word;
        for (int i = 0; i < 7; i++)
            vals[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            k       = $urandom_range(0, i);
            tmp     = vals[i];
            vals[i] = vals[k];
            vals[k] = tmp;
        end
        perm_word = PERM_W'($urandom);
        for (int i = 0; i < n; i++)
            perm_word[(n - 1 - i) * PIECE_BITS +: PIECE_BITS] = PIECE_BITS'(vals[i]);
        return perm_word;
    endfunction

    // Driver: one command per transfer, random gaps with occasional bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                expected_results.push_back(predict_conversion(cur_cmd));

            if (start && busy)
            begin
                start <= 1'b1;
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].hold && expected_results.size() != 0))
            begin
                cur_cmd = pending_cmds.pop_front();
                operation   <= cur_cmd.op;
                piece_count <= cur_cmd.count;
                perm_in     <= cur_cmd.perm;
                rank_in     <= cur_cmd.rank;
                start       <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_mode = ($urandom_range(0, 3) == 0);
                    burst_left = $urandom_range(10, 60);
                end
                burst_left--;
                gap_left = burst_mode ? 0 : $urandom_range(0, 3);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every done cycle is a transfer
    always @(posedge clk)
    begin
        conv_result_t exp_res;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no command outstanding: perm_out=%0h rank_out=%0d",
                       perm_out, rank_out);
                fail_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (perm_out !== exp_res.perm)
                begin
                    $error("perm_out: expected %0o, actual %0o", exp_res.perm, perm_out);
                    fail_count++;
                end
                if (rank_out !== exp_res.rank)
                begin
                    $error("rank_out: expected %0d, actual %0d", exp_res.rank, rank_out);
                    fail_count++;
                end
                if (rank_invalid !== exp_res.invalid)
                begin
                    $error("rank_invalid: expected %0b, actual %0b",
                           exp_res.invalid, rank_invalid);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int n;
        int drain_cycles;

        // directed: identity, reverse, bounds, empty and single-piece, repeats
        add_cmd(OP_RANK,   7, 21'o0123456, 13'h1FFF);
        add_cmd(OP_RANK,   7, 21'o6543210, '0);
        add_cmd(OP_RANK,   7, '0, '0);
        add_cmd(OP_RANK,   7, 21'o7777777, '0);
        add_cmd(OP_RANK,   7, 21'o7654321, '0);
        add_cmd(OP_RANK,   3, 21'o5555210, '0);
        add_cmd(OP_RANK,   0, 21'o7777777, 13'h1FFF);
        add_cmd(OP_RANK,   1, 21'o7777777, '0);
        add_cmd(OP_UNRANK, 7, 21'o7777777, 13'd0);
        add_cmd(OP_UNRANK, 7, '0, 13'd5039);
        add_cmd(OP_UNRANK, 7, '0, 13'd5040);
        add_cmd(OP_UNRANK, 7, '0, 13'h1FFF);
        add_cmd(OP_UNRANK, 0, '0, 13'd0);
        add_cmd(OP_UNRANK, 0, '0, 13'd1);
        add_cmd(OP_UNRANK, 1, '0, 13'd0);
        add_cmd(OP_UNRANK, 1, '0, 13'd1);
        add_cmd(OP_UNRANK, 2, '0, 13'd1);
        add_cmd(OP_UNRANK, 6, '0, 13'd719, 1'b1);
        add_cmd(OP_UNRANK, 6, '0, 13'd720);
        add_cmd(OP_UNRANK, 5, '0, 13'd77);

        for (int i = 0; i < 1600; i++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                n = $urandom_range(1, 7);
                if ($urandom_range(0, 1) == 0)
                    add_cmd(OP_RANK, n, random_perm(n), RANK_W'($urandom), (i % 400) == 399);
                else
                    add_cmd(OP_UNRANK, n, PERM_W'($urandom),
                            RANK_W'($urandom_range(0, factorial(n) - 1)), (i % 400) == 399);
            end
            else
            begin
                n = $urandom_range(0, 7);
                if ($urandom_range(0, 2) == 0)
                    add_cmd(OP_UNRANK, n, PERM_W'($urandom),
                            RANK_W'(factorial(n) + $urandom_range(0, 2) - 1));
                else
                    add_cmd($urandom_range(0, 1) ? OP_UNRANK : OP_RANK, n,
                            PERM_W'($urandom), RANK_W'($urandom));
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start)
            @(posedge clk);
        drain_cycles = 0;
        while (expected_results.size() != 0 && drain_cycles < 200)
        begin
            drain_cycles++;
            @(posedge clk);
        end
        repeat (12) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
